>>> rtl/core/mchs_pkg.sv
// Shared constants, types and state codes for the motif consensus Hamming scorer.
`timescale 1ns / 1ps

package mchs_pkg;

    localparam int NUM_MOTIFS = 1024;
    localparam int MOTIF_LEN  = 16;
    localparam int NUM_AMINO  = 20;

    localparam int IDX_W  = 10;
    localparam int POS_W  = 4;
    localparam int CODE_W = 5;
    localparam int CNT_W  = 11;
    localparam int TOT_W  = 15;

    localparam int MOT_AW = (NUM_MOTIFS > 1) ? $clog2(NUM_MOTIFS) : 1;
    localparam int COL_W  = (MOTIF_LEN > 1) ? $clog2(MOTIF_LEN) : 1;
    localparam int RES_W  = $clog2(NUM_AMINO);
    localparam int PC_W   = $clog2(MOTIF_LEN + 1);

    localparam logic [CODE_W-1:0] CODE_OTHER = CODE_W'(NUM_AMINO);
    localparam logic [CNT_W-1:0]  COUNT_MAX  = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0]  COUNT_INIT = CNT_W'(1);
    localparam logic [TOT_W-1:0]  TOTAL_MAX  = {TOT_W{1'b1}};

    // Largest total that the stored motifs can produce.
    localparam int TOTAL_LIMIT = (NUM_MOTIFS * MOTIF_LEN < 32767) ?
                                 NUM_MOTIFS * MOTIF_LEN : 32767;

    typedef logic [CODE_W-1:0]                  code_t;
    typedef logic [MOTIF_LEN-1:0][CODE_W-1:0]   motif_row_t;
    typedef logic [NUM_AMINO-1:0][CNT_W-1:0]    count_row_t;

    // One count update: the residue leaving a column and the one entering it.
    typedef struct packed {
        code_t old_code;
        code_t new_code;
    } count_upd_t;

    typedef enum logic [6:0] {
        ST_CLEAR     = 7'b0000001,
        ST_IDLE      = 7'b0000010,
        ST_UPDATE    = 7'b0000100,
        ST_CONS_RD   = 7'b0001000,
        ST_CONS_SCAN = 7'b0010000,
        ST_MM        = 7'b0100000,
        ST_EMIT      = 7'b1000000
    } state_t;

endpackage

>>> rtl/core/mchs_count_update.sv
// Applies one residue replacement to a column's count row with saturation.
`timescale 1ns / 1ps

module mchs_count_update
    import mchs_pkg::*;
(
    input  count_row_t row_in,
    input  count_upd_t upd,
    output count_row_t row_out
);

    always_comb begin
        logic [CNT_W-1:0] v;
        for (int r = 0; r < NUM_AMINO; r++) begin
            v = row_in[r];
            // Old residue leaves the column; codes of "other" carry no count.
            if ((upd.old_code == CODE_W'(r)) && (v != '0)) begin
                v = v - CNT_W'(1);
            end
            if ((upd.new_code == CODE_W'(r)) && (v != COUNT_MAX)) begin
                v = v + CNT_W'(1);
            end
            row_out[r] = v;
        end
    end

endmodule

>>> rtl/core/mchs_row_mismatch.sv
// Counts the columns of one motif row that differ from the consensus row.
`timescale 1ns / 1ps

module mchs_row_mismatch
    import mchs_pkg::*;
(
    input  motif_row_t       row,
    input  motif_row_t       cons,
    output logic [PC_W-1:0]  mismatches
);

    logic [MOTIF_LEN-1:0] diff;

    always_comb begin
        for (int c = 0; c < MOTIF_LEN; c++) begin
            diff[c] = (row[c] != cons[c]);
        end
    end

    assign mismatches = PC_W'($countones(diff));

endmodule

>>> rtl/core/motif_consensus_hamming_scorer_top.sv
// Top level of the motif consensus Hamming scorer: stores, sequencer and stream ports.
`timescale 1ns / 1ps
// A word that does not ask for evaluation passes through a store read, then an update write.
// An evaluating word returns its result after the update, the consensus scan over every
// column, the mismatch sweep of all NUM_MOTIFS rows through the single motif store read
// port, and the emit step.
// After reset a clearing pass over the rows of both stores fills the motif store with
// code 20 and the count rows with ones; no word is accepted until it ends.

module motif_consensus_hamming_scorer_top
    import mchs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [9:0] seq_index, [13:10] position, [18:14] residue
    input  logic [1:0]  s_tuser,   // [0] evaluate, [1] first_of_run

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [14:0] mismatch_total, [29:15] best_total
    output logic [0:0]  m_tuser    // [0] new_best
);

    // The clearing pass covers whichever store has more rows.
    localparam int CLEAR_LEN = (NUM_MOTIFS > MOTIF_LEN) ? NUM_MOTIFS : MOTIF_LEN;
    localparam int CLR_W     = $clog2(CLEAR_LEN + 1);
    localparam int WIDE_W    = CLR_W + MOT_AW + COL_W + IDX_W + POS_W;

    // ------------------------------------------------------------------
    // Storage. The motif store holds one motif per row so the mismatch
    // sweep reads a whole motif each cycle; a single column is written
    // with a lane write. The count table holds one column per row.
    // ------------------------------------------------------------------
    motif_row_t motif_mem [NUM_MOTIFS];
    count_row_t cnt_mem   [MOTIF_LEN];

    state_t state_reg, state_next;

    logic [CLR_W-1:0]   clr_reg, clr_next;
    logic [MOT_AW-1:0]  row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    code_t              res_reg, res_next;
    logic               in_range_reg, in_range_next;
    logic               eval_reg, eval_next;
    logic               first_reg, first_next;

    logic [COL_W-1:0]   c_reg, c_next;
    logic [RES_W-1:0]   r_reg, r_next;
    logic [CNT_W-1:0]   top_reg, top_next;
    logic [RES_W-1:0]   arg_reg, arg_next;
    motif_row_t         cons_reg, cons_next;

    logic [MOT_AW:0]    m_reg, m_next;
    logic               mm_pend_reg, mm_pend_next;
    logic [TOT_W-1:0]   total_reg, total_next;
    logic [TOT_W-1:0]   best_reg, best_next;

    logic               m_valid_reg, m_valid_next;
    logic [TOT_W-1:0]   out_total_reg, out_total_next;
    logic [TOT_W-1:0]   out_best_reg, out_best_next;
    logic               out_new_best_reg, out_new_best_next;

    motif_row_t         motif_rd_reg;
    count_row_t         cnt_rd_reg;

    // Memory port controls.
    logic               motif_rd_en;
    logic [MOT_AW-1:0]  motif_rd_addr;
    logic               cnt_rd_en;
    logic [COL_W-1:0]   cnt_rd_addr;
    logic               clr_motif_we;
    logic               clr_cnt_we;
    logic               upd_we;

    // Input word fields.
    logic [IDX_W-1:0]   s_seq_index;
    logic [POS_W-1:0]   s_position;
    code_t              s_residue;
    logic               s_evaluate;
    logic               s_first_of_run;
    logic               s_accept;

    logic [WIDE_W-1:0]  seq_wide;
    logic [WIDE_W-1:0]  pos_wide;
    logic [WIDE_W-1:0]  clr_wide;
    code_t              res_clamped;

    count_upd_t         upd;
    count_row_t         cnt_new_row;
    logic [PC_W-1:0]    row_mm;
    logic [TOT_W:0]     sum_wide;
    logic [CNT_W-1:0]   scan_elem;
    logic               scan_gt;
    logic               out_free;
    logic               better;

    assign s_seq_index    = s_tdata[9:0];
    assign s_position     = s_tdata[13:10];
    assign s_residue      = s_tdata[18:14];
    assign s_evaluate     = s_tuser[0];
    assign s_first_of_run = s_tuser[1];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign seq_wide    = WIDE_W'(s_seq_index);
    assign pos_wide    = WIDE_W'(s_position);
    assign clr_wide    = WIDE_W'(clr_reg);
    // Codes above "other" are stored as "other".
    assign res_clamped = (s_residue > CODE_OTHER) ? CODE_OTHER : s_residue;

    // ------------------------------------------------------------------
    // Read-modify-write datapath for one residue write.
    // ------------------------------------------------------------------
    assign upd.old_code = motif_rd_reg[col_reg];
    assign upd.new_code = res_reg;

    mchs_count_update u_count_update (
        .row_in  (cnt_rd_reg),
        .upd     (upd),
        .row_out (cnt_new_row)
    );

    // Mismatch of the motif row that arrived from the store this cycle.
    mchs_row_mismatch u_row_mismatch (
        .row        (motif_rd_reg),
        .cons       (cons_reg),
        .mismatches (row_mm)
    );

    assign sum_wide  = {1'b0, total_reg} + (TOT_W + 1)'(row_mm);
    assign scan_elem = cnt_rd_reg[r_reg];
    assign scan_gt   = (scan_elem > top_reg);
    assign out_free  = !m_valid_reg || m_tready;
    assign better    = first_reg || (total_reg < best_reg);

    // ------------------------------------------------------------------
    // Memory port selection.
    // ------------------------------------------------------------------
    always_comb begin
        motif_rd_en   = 1'b0;
        motif_rd_addr = seq_wide[MOT_AW-1:0];
        cnt_rd_en     = 1'b0;
        cnt_rd_addr   = pos_wide[COL_W-1:0];
        clr_motif_we  = 1'b0;
        clr_cnt_we    = 1'b0;
        upd_we        = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                clr_motif_we = (clr_wide < WIDE_W'(NUM_MOTIFS));
                clr_cnt_we   = (clr_wide < WIDE_W'(MOTIF_LEN));
            end
            ST_IDLE: begin
                // Both stores are read as the word is taken.
                motif_rd_en = s_accept;
                cnt_rd_en   = s_accept;
            end
            ST_UPDATE: begin
                upd_we = in_range_reg;
            end
            ST_CONS_RD: begin
                cnt_rd_en   = 1'b1;
                cnt_rd_addr = c_reg;
            end
            ST_MM: begin
                motif_rd_en   = (m_reg < (MOT_AW + 1)'(NUM_MOTIFS));
                motif_rd_addr = m_reg[MOT_AW-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (clr_motif_we) begin
            motif_mem[clr_wide[MOT_AW-1:0]] <= {MOTIF_LEN{CODE_OTHER}};
        end else if (upd_we) begin
            motif_mem[row_reg][col_reg] <= res_reg;
        end
        if (motif_rd_en) begin
            motif_rd_reg <= motif_mem[motif_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_cnt_we) begin
            cnt_mem[clr_wide[COL_W-1:0]] <= {NUM_AMINO{COUNT_INIT}};
        end else if (upd_we) begin
            cnt_mem[col_reg] <= cnt_new_row;
        end
        if (cnt_rd_en) begin
            cnt_rd_reg <= cnt_mem[cnt_rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        state_next        = state_reg;
        clr_next          = clr_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        res_next          = res_reg;
        in_range_next     = in_range_reg;
        eval_next         = eval_reg;
        first_next        = first_reg;
        c_next            = c_reg;
        r_next            = r_reg;
        top_next          = top_reg;
        arg_next          = arg_reg;
        cons_next         = cons_reg;
        m_next            = m_reg;
        mm_pend_next      = mm_pend_reg;
        total_next        = total_reg;
        best_next         = best_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        out_total_next    = out_total_reg;
        out_best_next     = out_best_reg;
        out_new_best_next = out_new_best_reg;

        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + CLR_W'(1);
                if (clr_reg == CLR_W'(CLEAR_LEN - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    row_next      = seq_wide[MOT_AW-1:0];
                    col_next      = pos_wide[COL_W-1:0];
                    res_next      = res_clamped;
                    in_range_next = (seq_wide < WIDE_W'(NUM_MOTIFS)) &&
                                    (pos_wide < WIDE_W'(MOTIF_LEN));
                    eval_next     = s_evaluate;
                    first_next    = s_first_of_run;
                    state_next    = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                c_next = '0;
                r_next = '0;
                state_next = eval_reg ? ST_CONS_RD : ST_IDLE;
            end
            ST_CONS_RD: begin
                state_next = ST_CONS_SCAN;
            end
            ST_CONS_SCAN: begin
                // Strictly greater wins, so ties stay with the lower code.
                if (r_reg == '0) begin
                    top_next = scan_elem;
                    arg_next = '0;
                end else if (scan_gt) begin
                    top_next = scan_elem;
                    arg_next = r_reg;
                end
                if (r_reg == RES_W'(NUM_AMINO - 1)) begin
                    cons_next[c_reg] = CODE_W'(scan_gt ? r_reg : arg_reg);
                    r_next = '0;
                    c_next = c_reg + COL_W'(1);
                    if (c_reg == COL_W'(MOTIF_LEN - 1)) begin
                        m_next       = '0;
                        mm_pend_next = 1'b0;
                        total_next   = '0;
                        state_next   = ST_MM;
                    end else begin
                        state_next = ST_CONS_RD;
                    end
                end else begin
                    r_next = r_reg + RES_W'(1);
                end
            end
            ST_MM: begin
                // One row is issued per cycle; its data is summed in the cycle after.
                if (m_reg < (MOT_AW + 1)'(NUM_MOTIFS)) begin
                    m_next       = m_reg + (MOT_AW + 1)'(1);
                    mm_pend_next = 1'b1;
                end else begin
                    mm_pend_next = 1'b0;
                    if (!mm_pend_reg) begin
                        state_next = ST_EMIT;
                    end
                end
                if (mm_pend_reg) begin
                    total_next = (sum_wide > (TOT_W + 1)'(TOTAL_MAX)) ? TOTAL_MAX
                                                                      : sum_wide[TOT_W-1:0];
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    out_total_next    = total_reg;
                    out_new_best_next = better;
                    out_best_next     = better ? total_reg : best_reg;
                    best_next         = better ? total_reg : best_reg;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            best_reg    <= '0;
            mm_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            best_reg    <= best_next;
            mm_pend_reg <= mm_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg          <= row_next;
        col_reg          <= col_next;
        res_reg          <= res_next;
        in_range_reg     <= in_range_next;
        eval_reg         <= eval_next;
        first_reg        <= first_next;
        c_reg            <= c_next;
        r_reg            <= r_next;
        top_reg          <= top_next;
        arg_reg          <= arg_next;
        cons_reg         <= cons_next;
        m_reg            <= m_next;
        total_reg        <= total_next;
        out_total_reg    <= out_total_next;
        out_best_reg     <= out_best_next;
        out_new_best_reg <= out_new_best_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_best_reg, out_total_reg};
    assign m_tuser  = out_new_best_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A result word only appears from the emit step.
    a_valid_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_EMIT))
        else $error("result word raised outside the emit step");

    // A new best carries its own total as the best.
    a_new_best_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[29:15] == m_tdata[14:0]))
        else $error("new best word with best total different from its total");

    // Without a new best, the kept best is no worse than this total.
    a_best_not_worse: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[29:15] <= m_tdata[14:0]))
        else $error("kept best total exceeds the reported total");

    // The total can never exceed the number of stored residues.
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[14:0] <= TOT_W'(TOTAL_LIMIT)))
        else $error("mismatch total exceeds the number of stored residues");

endmodule
